// File: src/sapq_pkg.sv
package sapq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;

	localparam int TAG_W   = 16;
	localparam int TIME_W  = 32;
	localparam int KEY_W   = 33;
	localparam int LIMIT_W = 5;
	localparam int OCNT_W  = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		KIND_ENQ   = 2'd0,
		KIND_SERVE = 2'd1,
		KIND_PEEK  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_FETCH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  tag;
		logic [KEY_W-1:0]  key;
		logic [OCNT_W-1:0] count;
	} result_t;

	// count as seen on the result: low five bits of the held count
	function automatic logic [OCNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
		logic [CNT_W+OCNT_W-1:0] w;
		w = (CNT_W + OCNT_W)'(c);
		return w[OCNT_W-1:0];
	endfunction

endpackage

// File: src/sapq_mem.sv
module sapq_mem (
	input  logic              clk,
	input  sapq_pkg::mem_req_t req,
	output sapq_pkg::entry_t   rdata
);
	import sapq_pkg::*;

	entry_t mem [QUEUE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/sapq_ctrl.sv
module sapq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sapq_pkg::LIMIT_W-1:0]   limit,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     kind,
	input  logic [sapq_pkg::TAG_W-1:0]     item_tag,
	input  logic [sapq_pkg::TIME_W-1:0]    arrival_time,
	input  logic [sapq_pkg::TIME_W-1:0]    stay_time,
	output sapq_pkg::mem_req_t             mem_req,
	input  sapq_pkg::entry_t               mem_rdata,
	output logic                           res_valid,
	output sapq_pkg::result_t              res,
	input  logic                           res_take
);
	import sapq_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  held_q, held_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	entry_t            new_q, new_d;
	kind_t             kind_q, kind_d;
	result_t           res_q, res_d;
	logic              res_load;

	logic [CNT_W-1:0]  held_m1;
	logic [KEY_W-1:0]  key_sum;
	logic              full;

	assign held_m1 = held_q - CNT_W'(1);
	assign key_sum = KEY_W'(arrival_time) + KEY_W'(stay_time);
	// limits above the depth act as the depth, since held never exceeds it
	assign full = (CMP_W'(held_q) >= CMP_W'(limit)) ||
	              (CMP_W'(held_q) == CMP_W'(QUEUE_DEPTH));

	always_comb begin
		state_d       = state_q;
		held_d        = held_q;
		pos_d         = pos_q;
		new_d         = new_q;
		kind_d        = kind_q;
		res_d         = res_q;
		res_load      = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = new_q;
		mem_req.raddr = held_m1[ADDR_W-1:0];
		res_d.status  = STATUS_OK;
		res_d.tag     = '0;
		res_d.key     = '0;
		req_stall     = (state_q != ST_IDLE);
		res_valid     = (state_q == ST_RESULT);

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					kind_d      = kind_t'(kind);
					new_d.tag   = item_tag;
					new_d.key   = key_sum;
					pos_d       = held_q[ADDR_W-1:0];
					unique case (kind_t'(kind))
						KIND_ENQ: begin
							if (full) begin
								res_d.status = STATUS_FULL;
								res_load     = 1'b1;
								state_d      = ST_RESULT;
							end else if (held_q == '0) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = '0;
								mem_req.wdata = '{tag: item_tag, key: key_sum};
								held_d        = held_q + CNT_W'(1);
								res_load      = 1'b1;
								state_d       = ST_RESULT;
							end else begin
								state_d = ST_SCAN;
							end
						end
						KIND_SERVE, KIND_PEEK: begin
							if (held_q == '0) begin
								res_d.status = STATUS_EMPTY;
								res_load     = 1'b1;
								state_d      = ST_RESULT;
							end else begin
								state_d = ST_FETCH;
							end
						end
						KIND_NOP: begin
							res_load = 1'b1;
							state_d  = ST_RESULT;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// mem_rdata holds slot pos_q-1; read of pos_q-2 goes out meanwhile
				if (mem_rdata.key < new_q.key) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = mem_rdata;
					pos_d         = pos_q - ADDR_W'(1);
					mem_req.raddr = pos_q - ADDR_W'(2);
					if (pos_q == ADDR_W'(1)) begin
						state_d = ST_PLACE;
					end
				end else begin
					mem_req.we = 1'b1;
					held_d     = held_q + CNT_W'(1);
					res_load   = 1'b1;
					state_d    = ST_RESULT;
				end
			end
			ST_PLACE: begin
				mem_req.we = 1'b1;
				held_d     = held_q + CNT_W'(1);
				res_load   = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_FETCH: begin
				res_d.tag = mem_rdata.tag;
				res_d.key = mem_rdata.key;
				if (kind_q == KIND_SERVE) begin
					held_d = held_m1;
				end
				res_load = 1'b1;
				state_d  = ST_RESULT;
			end
			ST_RESULT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		res_d.count = count_out(held_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		new_q  <= new_d;
		kind_q <= kind_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

// File: src/sorted_array_priority_queue_core.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  kind, item_tag, arrival_time, stay_time
// rsp      out        rsp_valid/rsp_stall  status, out_tag, out_key, entry_count
// cfg      in         cfg_we               cfg_wdata (capacity limit)
//
// Serve and peek pass through a fetch state before the result; rejected or trivial
// items go straight to the result. An enqueue walks the entry memory one slot a cycle.
// Reset empties the queue at once and sets the limit to 16; no clearing pass.
// A waiting result sits in the output register while the next item is worked on;
// a stalled rsp side holds the core only once a second result is ready.
module sorted_array_priority_queue_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     kind,
	input  logic [sapq_pkg::TAG_W-1:0]     item_tag,
	input  logic [sapq_pkg::TIME_W-1:0]    arrival_time,
	input  logic [sapq_pkg::TIME_W-1:0]    stay_time,
	input  logic                           cfg_we,
	input  logic [sapq_pkg::LIMIT_W-1:0]   cfg_wdata,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [1:0]                     status,
	output logic [sapq_pkg::TAG_W-1:0]     out_tag,
	output logic [sapq_pkg::KEY_W-1:0]     out_key,
	output logic [sapq_pkg::OCNT_W-1:0]    entry_count
);
	import sapq_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	mem_req_t           mem_req;
	entry_t             mem_rdata;
	logic               res_valid;
	result_t            res;
	logic               res_take;
	logic               rsp_valid_q;
	result_t            rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	sapq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.limit        (limit_q),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.item_tag     (item_tag),
		.arrival_time (arrival_time),
		.stay_time    (stay_time),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	sapq_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// output register: refilled when empty or being drained this cycle
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_q.status;
	assign out_tag     = rsp_q.tag;
	assign out_key     = rsp_q.key;
	assign entry_count = rsp_q.count;

endmodule

// File: tb/sv/sapq_order_checker.sv
`timescale 1ns / 100ps

module sapq_order_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic [1:0]                    kind,
	input  logic [sapq_pkg::TAG_W-1:0]    item_tag,
	input  logic [sapq_pkg::TIME_W-1:0]   arrival_time,
	input  logic [sapq_pkg::TIME_W-1:0]   stay_time,
	input  logic                          cfg_we,
	input  logic [sapq_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic [1:0]                    status,
	input  logic [sapq_pkg::TAG_W-1:0]    out_tag,
	input  logic [sapq_pkg::KEY_W-1:0]    out_key,
	input  logic [sapq_pkg::OCNT_W-1:0]   entry_count,
	output int                            mismatches,
	output int                            outstanding,
	output int                            full_seen,
	output int                            empty_seen
);
	import sapq_pkg::*;

	// shadow of the queue: slot 0 largest key, tail smallest
	entry_t           slots [QUEUE_DEPTH];
	int unsigned      held;
	logic [LIMIT_W-1:0] limit_reg;
	result_t          due_rsp [$];
	result_t          want;
	int               err_cnt = 0;
	int               full_cnt = 0;
	int               empty_cnt = 0;

	function automatic result_t run_queue_op(input kind_t k, input logic [TAG_W-1:0] tg,
			input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] s);
		result_t     r;
		int unsigned cap;
		int unsigned pos;
		logic [KEY_W-1:0] nk;
		r.status = STATUS_OK;
		r.tag    = '0;
		r.key    = '0;
		cap = (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : limit_reg;
		case (k)
			KIND_ENQ: begin
				if (held >= cap) begin
					r.status = STATUS_FULL;
				end else begin
					nk  = {1'b0, a} + {1'b0, s};
					pos = held;
					// newest goes past strictly smaller keys only, so it wins ties
					while (pos > 0 && slots[pos-1].key < nk) begin
						slots[pos] = slots[pos-1];
						pos--;
					end
					slots[pos].tag = tg;
					slots[pos].key = nk;
					held++;
				end
			end
			KIND_SERVE, KIND_PEEK: begin
				if (held == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.tag = slots[held-1].tag;
					r.key = slots[held-1].key;
					if (k == KIND_SERVE)
						held--;
				end
			end
			default: ;
		endcase
		r.count = held[OCNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held      = 0;
			limit_reg = LIMIT_RESET;
			due_rsp.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				limit_reg = cfg_wdata;
			// older results leave before a new item is booked
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					$display("%0t: unexpected result status %0d tag %h key %h count %0d",
						$time, status, out_tag, out_key, entry_count);
					err_cnt++;
				end else begin
					want = due_rsp.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
						err_cnt++;
					end
					if (out_tag !== want.tag) begin
						$display("%0t: out_tag expected %h got %h", $time, want.tag, out_tag);
						err_cnt++;
					end
					if (out_key !== want.key) begin
						$display("%0t: out_key expected %h got %h", $time, want.key, out_key);
						err_cnt++;
					end
					if (entry_count !== want.count) begin
						$display("%0t: entry_count expected %0d got %0d",
							$time, want.count, entry_count);
						err_cnt++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				want = run_queue_op(kind_t'(kind), item_tag, arrival_time, stay_time);
				if (want.status == STATUS_FULL)
					full_cnt++;
				if (want.status == STATUS_EMPTY)
					empty_cnt++;
				due_rsp.push_back(want);
			end
			outstanding <= due_rsp.size();
		end
		mismatches <= err_cnt;
		full_seen  <= full_cnt;
		empty_seen <= empty_cnt;
	end

endmodule

// File: tb/sv/tb_sorted_array_priority_queue_core.sv
`timescale 1ns / 100ps

module tb_sorted_array_priority_queue_core;
	import sapq_pkg::*;

	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int LONG_HOLD       = 150;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 25;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [1:0]          kind = KIND_NOP;
	logic [TAG_W-1:0]    item_tag = '0;
	logic [TIME_W-1:0]   arrival_time = '0;
	logic [TIME_W-1:0]   stay_time = '0;
	logic                cfg_we = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [1:0]          status;
	logic [TAG_W-1:0]    out_tag;
	logic [KEY_W-1:0]    out_key;
	logic [OCNT_W-1:0]   entry_count;

	int mismatches;
	int outstanding;
	int full_seen;
	int empty_seen;

	logic calm = 1'b0;
	int   hold_ticket = 0;
	int   hold_seen = 0;
	int   stall_left = 0;
	int   free_left = 0;
	int   quiet_cycles = 0;
	int   n_enq = 0, n_serve = 0, n_peek = 0, n_nop = 0;

	always #5 clk = ~clk;

	sorted_array_priority_queue_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.item_tag     (item_tag),
		.arrival_time (arrival_time),
		.stay_time    (stay_time),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.out_tag      (out_tag),
		.out_key      (out_key),
		.entry_count  (entry_count)
	);

	sapq_order_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.item_tag     (item_tag),
		.arrival_time (arrival_time),
		.stay_time    (stay_time),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.out_tag      (out_tag),
		.out_key      (out_key),
		.entry_count  (entry_count),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.full_seen    (full_seen),
		.empty_seen   (empty_seen)
	);

	// result side: random stall bursts, free stretches, and a long hold on request
	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen  <= hold_ticket;
			stall_left <= LONG_HOLD - 1;
			rsp_stall  <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if (calm) begin
			rsp_stall <= 1'b0;
		end else if (free_left > 0) begin
			free_left <= free_left - 1;
			rsp_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0, 1: begin
					stall_left <= $urandom_range(0, 14);
					rsp_stall  <= 1'b1;
				end
				2: begin
					free_left <= $urandom_range(20, 60);
					rsp_stall <= 1'b0;
				end
				default: rsp_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input kind_t k, input logic [TAG_W-1:0] tg,
			input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] s);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_valid    <= 1'b1;
		kind         <= k;
		item_tag     <= tg;
		arrival_time <= a;
		stay_time    <= s;
		case (k)
			KIND_ENQ:   n_enq++;
			KIND_SERVE: n_serve++;
			KIND_PEEK:  n_peek++;
			default:    n_nop++;
		endcase
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
	endtask

	task automatic wait_results_in();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		wait_results_in();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] pick_time(input int mode);
		case (mode)
			0: return TIME_W'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] phase_limit(input int ph);
		case (ph)
			0: return 5'd16;
			1: return 5'd31;
			2: return 5'd3;
			3: return 5'd1;
			4: return 5'd0;
			5: return LIMIT_W'($urandom_range(1, 16));
			6: return 5'd16;
			7: return 5'd2;
			8: return 5'd20;
			default: return 5'd16;
		endcase
	endfunction

	initial begin
		int    ph;
		int    n;
		int    r;
		int    enq_pct;
		int    mode;
		kind_t k;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: serve, peek and the unused kind
		send_item(KIND_SERVE, 16'hA5A5, 32'hFFFF_FFFF, 32'h1);
		send_item(KIND_PEEK,  16'h5A5A, 32'h0, 32'hFFFF_FFFF);
		send_item(KIND_NOP,   16'hFFFF, 32'h1234_5678, 32'h9ABC_DEF0);
		// largest key, zero key, and a tie where the newer must come out first
		send_item(KIND_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_ENQ, 16'h0000, 32'h0, 32'h0);
		send_item(KIND_ENQ, 16'h1111, 32'd100, 32'd5);
		send_item(KIND_ENQ, 16'h2222, 32'd5, 32'd100);
		send_item(KIND_PEEK,  16'h0, 32'h0, 32'h0);
		repeat (4) send_item(KIND_SERVE, 16'h0, 32'h0, 32'h0);
		send_item(KIND_SERVE, 16'h0, 32'h0, 32'h0);
		// small limit, then lowered below the count held
		write_limit(5'd2);
		send_item(KIND_ENQ, 16'h0101, 32'd7, 32'd7);
		send_item(KIND_ENQ, 16'h0202, 32'd9, 32'd1);
		send_item(KIND_ENQ, 16'h0303, 32'd1, 32'd1);
		send_item(KIND_NOP, 16'h0, 32'h0, 32'h0);
		write_limit(5'd1);
		send_item(KIND_ENQ, 16'h0404, 32'd0, 32'd3);
		send_item(KIND_SERVE, 16'h0, 32'h0, 32'h0);
		send_item(KIND_SERVE, 16'h0, 32'h0, 32'h0);
		write_limit(5'd0);
		send_item(KIND_ENQ, 16'h0505, 32'd2, 32'd2);
		send_item(KIND_PEEK, 16'h0, 32'h0, 32'h0);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_limit(phase_limit(ph));
			if (ph == NUM_PHASES - 1)
				calm <= 1'b1;
			// long hold on the result side while items keep coming
			if (ph == 3 || ph == 8)
				hold_ticket <= hold_ticket + 1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 6 && n == ITEMS_PER_PHASE / 2)
					wait_results_in();
				// fill in the first half, drain in the second
				enq_pct = (n < ITEMS_PER_PHASE / 2) ? 70 : 35;
				r = $urandom_range(0, 99);
				if (r < enq_pct)
					k = KIND_ENQ;
				else if (r < 96)
					k = ($urandom_range(0, 2) == 0) ? KIND_PEEK : KIND_SERVE;
				else
					k = KIND_NOP;
				mode = $urandom_range(0, 3);
				send_item(k, TAG_W'($urandom_range(0, 65535)), pick_time(mode), pick_time(mode));
			end
		end

		wait_results_in();
		repeat (40) @(posedge clk);
		$display("Ran %0d enqueues, %0d serves, %0d peeks, %0d no-ops; limits 0 to 31.",
			n_enq, n_serve, n_peek, n_nop);
		$display("Rejected as full: %0d, empty serve or peek: %0d.", full_seen, empty_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
